// ===== sv/cpualu_pkg.sv =====
// ----------------------------------------------------------------------------
// cpualu_pkg
// Operation codes, flag positions and the operand bundle of the
// accumulator ALU.
// ----------------------------------------------------------------------------
package cpualu_pkg;

    typedef enum logic [3:0] {
        CMD_ADD = 4'd0,
        CMD_ADC = 4'd1,
        CMD_SUB = 4'd2,
        CMD_SBC = 4'd3,
        CMD_AND = 4'd4,
        CMD_XOR = 4'd5,
        CMD_OR  = 4'd6,
        CMD_CP  = 4'd7,
        CMD_INC = 4'd8,
        CMD_DEC = 4'd9,
        CMD_RLC = 4'd10,
        CMD_RL  = 4'd11,
        CMD_RRC = 4'd12,
        CMD_RR  = 4'd13,
        CMD_BIT = 4'd14
    } t_cmd;

    localparam int FLAG_Z = 3;
    localparam int FLAG_N = 2;
    localparam int FLAG_H = 1;
    localparam int FLAG_C = 0;

    localparam int IN_WIDTH  = 27;
    localparam int OUT_WIDTH = 12;

    typedef struct packed {
        logic [3:0] flags_in;
        logic [2:0] bit_index;
        logic [7:0] operand_b;
        logic [7:0] operand_a;
        logic [3:0] command;
    } t_alu_in;

    typedef struct packed {
        logic [3:0] flags_out;
        logic [7:0] result;
    } t_alu_out;

endpackage

// ===== sv/cpualu_core.sv =====
// ----------------------------------------------------------------------------
// cpualu_core
// Combinational datapath: result byte and new Z/N/H/C flags for one
// operation.
// ----------------------------------------------------------------------------
module cpualu_core
    import cpualu_pkg::*;
(
    input  t_alu_in  i_op,
    output t_alu_out o_res
);

    logic [7:0] a;
    logic [7:0] b;
    logic       cin;
    logic       c_use;
    logic [8:0] sum;
    logic [4:0] sum_lo;
    logic [8:0] diff;
    logic [4:0] diff_lo;
    logic [7:0] r;
    logic [3:0] f;

    assign a   = i_op.operand_a;
    assign b   = i_op.operand_b;
    assign cin = i_op.flags_in[FLAG_C];

    assign c_use = ((i_op.command == CMD_ADC) || (i_op.command == CMD_SBC)) ? cin : 1'b0;

    assign sum     = {1'b0, a} + {1'b0, b} + {8'd0, c_use};
    assign sum_lo  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, c_use};
    assign diff    = {1'b0, a} - {1'b0, b} - {8'd0, c_use};
    assign diff_lo = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, c_use};

    always_comb begin
        r = a;
        f = i_op.flags_in;
        unique case (i_op.command)
            CMD_ADD, CMD_ADC: begin
                r = sum[7:0];
                f = {(sum[7:0] == 8'd0), 1'b0, sum_lo[4], sum[8]};
            end
            CMD_SUB, CMD_SBC: begin
                r = diff[7:0];
                f = {(diff[7:0] == 8'd0), 1'b1, diff_lo[4], diff[8]};
            end
            CMD_CP: begin
                f = {(diff[7:0] == 8'd0), 1'b1, diff_lo[4], diff[8]};
            end
            CMD_AND: begin
                r = a & b;
                f = {((a & b) == 8'd0), 1'b0, 1'b1, 1'b0};
            end
            CMD_XOR: begin
                r = a ^ b;
                f = {((a ^ b) == 8'd0), 3'b000};
            end
            CMD_OR: begin
                r = a | b;
                f = {((a | b) == 8'd0), 3'b000};
            end
            CMD_INC: begin
                r = a + 8'd1;
                f = {(a == 8'hFF), 1'b0, (a[3:0] == 4'hF), cin};
            end
            CMD_DEC: begin
                r = a - 8'd1;
                f = {(a == 8'h01), 1'b1, (a[3:0] == 4'h0), cin};
            end
            CMD_RLC: begin
                r = {a[6:0], a[7]};
                f = {3'b000, a[7]};
            end
            CMD_RL: begin
                r = {a[6:0], cin};
                f = {3'b000, a[7]};
            end
            CMD_RRC: begin
                r = {a[0], a[7:1]};
                f = {3'b000, a[0]};
            end
            CMD_RR: begin
                r = {cin, a[7:1]};
                f = {3'b000, a[0]};
            end
            CMD_BIT: begin
                f = {~b[i_op.bit_index], 1'b0, 1'b1, cin};
            end
            default: begin
                r = a;
                f = i_op.flags_in;
            end
        endcase
    end

    assign o_res.result    = r;
    assign o_res.flags_out = f;

endmodule

// ===== sv/cpu_alu_with_flags.sv =====
// ----------------------------------------------------------------------------
// cpu_alu_with_flags
// Accumulator ALU with Z/N/H/C flags, registered in and out.
// ----------------------------------------------------------------------------
// Input items arrive on the slave stream (i_s_*) and carry the command, both
// operand bytes, the bit index and the incoming flags. Each item yields one
// result item on the master stream (o_m_*) with the result byte and the new
// flags. An item is captured in the input register, goes through the
// combinational datapath and lands in the result register, so its result is
// offered once it reaches the result register. One item is accepted every
// cycle unless the receiver stalls; the throughput is set by the single
// register stage on each side of the datapath. When the receiver stalls, the
// result register holds its item and the input register can still take one
// more; after that the input side deasserts tready until the receiver moves.
// Reset empties both registers; no item is pending after reset.
// ----------------------------------------------------------------------------
module cpu_alu_with_flags
    import cpualu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // command[3:0], operand_a[11:4], operand_b[19:12], bit_index[22:20],
    // flags_in[26:23], zero fill[31:27]
    input  logic [31:0] i_s_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // result[7:0], flags_out[11:8], zero fill[15:12]
    output logic [15:0] o_m_tdata
);

    logic     r_in_valid;
    t_alu_in  r_in;
    logic     r_out_valid;
    t_alu_out r_out;
    t_alu_out core_res;
    logic     out_free;
    logic     in_free;
    logic     in_take;

    cpualu_core u_core (
        .i_op  (r_in),
        .o_res (core_res)
    );

    assign out_free = !r_out_valid || i_m_tready;
    assign in_free  = !r_in_valid || out_free;
    assign in_take  = i_s_tvalid && in_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_free) begin
                r_in_valid <= i_s_tvalid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= t_alu_in'(i_s_tdata[IN_WIDTH-1:0]);
        end
        if (out_free && r_in_valid) begin
            r_out <= core_res;
        end
    end

    assign o_s_tready = in_free;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(16 - OUT_WIDTH){1'b0}}, r_out};

    a_take_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> r_in_valid)
        else $error("Accepted item did not reach the input register.");

    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && out_free) |=> (r_out_valid && (r_out == $past(core_res))))
        else $error("Result register did not capture the datapath output.");

    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (r_in_valid && r_out_valid && !i_m_tready))
        else $error("Input side stalled while a register was free.");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_in_valid && !r_out_valid))
        else $error("Registers not emptied by reset.");

endmodule
